// File: design/fswtc_pkg.sv
// ----------------------------------------------------------------------------
// fswtc_pkg
// Shared sizes, codes and interface types of the four-set write-through cache.
// ----------------------------------------------------------------------------
package fswtc_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int ADDR_W    = 10;
    localparam int DATA_W    = 64;
    localparam int SET_CNT   = 4;
    localparam int SET_W     = $clog2(SET_CNT);
    localparam int SET_LSB   = 4;
    localparam int WAYS      = 4;
    localparam int WAY_W     = $clog2(WAYS);
    localparam int FILL_W    = $clog2(WAYS + 1);
    localparam int ENTRIES   = SET_CNT * WAYS;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // register index, taken from paddr above the byte offset
    localparam logic REG_CACHE_BYPASS = 1'b0;

    typedef enum logic [1:0] {
        ACC_BYPASS = 2'd0,
        ACC_HIT    = 2'd1,
        ACC_MISS   = 2'd2
    } t_acc_status;

    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;   // latch request, start backing memory read
        logic commit;    // compare tags, update cache and memory, latch result
    } t_ctrl_cmd;

endpackage

// File: design/four_set_write_through_cache.sv
// ----------------------------------------------------------------------------
// four_set_write_through_cache
// Word memory with a four-set, four-way write-through read cache in front.
// ----------------------------------------------------------------------------
// Request channel: drive start with i_func (0 read, 1 write), i_word_address
// and i_write_value; the transfer is taken at a rising edge with start high
// and busy low. Address bits 5..4 select the cache set.
// Result channel: o_done is high for exactly one cycle with o_read_value
// (zero for writes) and o_access_status (bypass, hit or miss). The receiver
// must take it in that cycle; there is no way to hold it off.
// Sequence: the accepting edge captures the request and reads the backing
// memory synchronously; the lookup state then compares tags and updates the
// cache and memory, and the result strobe is registered from it. busy is high
// in the lookup state, so a new access is taken only once the last is through.
// Configuration: APB register 0 (byte address 0), bit 0 is cache bypass.
// Write it only while no access is in flight.
// Reset: clears the bypass bit, the sequencer and all set fill counts, so
// the cache starts empty. The backing memory is not cleared; a word must be
// written before it is read.
// ----------------------------------------------------------------------------
module four_set_write_through_cache (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fswtc_pkg::PADDR_W-1:0]       paddr,
    input  logic [fswtc_pkg::PDATA_W-1:0]       pwdata,
    output logic [fswtc_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [fswtc_pkg::ADDR_W-1:0]        i_word_address,
    input  logic signed [fswtc_pkg::DATA_W-1:0] i_write_value,
    output logic                                o_done,
    output logic signed [fswtc_pkg::DATA_W-1:0] o_read_value,
    output logic [1:0]                          o_access_status
);

    fswtc_pkg::t_ctrl_cmd w_cmd;
    logic                 w_bypass;

    fswtc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_bypass (w_bypass)
    );

    fswtc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    fswtc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_bypass        (w_bypass),
        .i_func          (i_func),
        .i_word_address  (i_word_address),
        .i_write_value   (i_write_value),
        .o_read_value    (o_read_value),
        .o_access_status (o_access_status)
    );

endmodule

// File: design/fswtc_regs.sv
// ----------------------------------------------------------------------------
// fswtc_regs
// APB-style configuration register file holding the cache bypass bit.
// ----------------------------------------------------------------------------
module fswtc_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fswtc_pkg::PADDR_W-1:0]    paddr,
    input  logic [fswtc_pkg::PDATA_W-1:0]    pwdata,
    output logic [fswtc_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready,
    output logic                             o_bypass
);

    logic r_bypass;
    logic n_bypass;
    logic w_wr_bypass;

    assign pready      = 1'b1;
    assign w_wr_bypass = psel && penable && pwrite
                         && (paddr[2] == fswtc_pkg::REG_CACHE_BYPASS);

    always_comb begin
        n_bypass = r_bypass;
        if (w_wr_bypass) begin
            n_bypass = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
        end else begin
            r_bypass <= n_bypass;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == fswtc_pkg::REG_CACHE_BYPASS) begin
            prdata = {{(fswtc_pkg::PDATA_W-1){1'b0}}, r_bypass};
        end
    end

    assign o_bypass = r_bypass;

endmodule

// File: design/fswtc_ctrl.sv
// ----------------------------------------------------------------------------
// fswtc_ctrl
// Access sequencer: capture cycle, then lookup and update cycle.
// ----------------------------------------------------------------------------
module fswtc_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    output logic                   o_done,
    output fswtc_pkg::t_ctrl_cmd   o_cmd
);

    fswtc_pkg::t_state r_state;
    fswtc_pkg::t_state n_state;
    logic              r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fswtc_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = fswtc_pkg::ST_LOOKUP;
                end
            end
            fswtc_pkg::ST_LOOKUP: begin
                n_state = fswtc_pkg::ST_IDLE;
            end
            default: begin
                n_state = fswtc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b0;
        case (r_state)
            fswtc_pkg::ST_IDLE: begin
                o_cmd.capture = start;
            end
            fswtc_pkg::ST_LOOKUP: begin
                o_cmd.commit = 1'b1;
                busy         = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fswtc_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.commit;
        end
    end

    assign o_done = r_done;

`ifndef SYNTHESIS
    // every accepted transfer yields its result strobe once the lookup state has committed
    a_capture_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> ##1 o_done)
        else $error("result strobe missing after capture");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_no_cmd_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.commit))
        else $error("capture during commit");
`endif

endmodule

// File: design/fswtc_dp.sv
// ----------------------------------------------------------------------------
// fswtc_dp
// Datapath: backing word memory, four-set cache arrays, tag compare, result.
// ----------------------------------------------------------------------------
module fswtc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fswtc_pkg::t_ctrl_cmd                i_cmd,
    input  logic                                i_bypass,
    input  logic                                i_func,
    input  logic [fswtc_pkg::ADDR_W-1:0]        i_word_address,
    input  logic signed [fswtc_pkg::DATA_W-1:0] i_write_value,
    output logic signed [fswtc_pkg::DATA_W-1:0] o_read_value,
    output logic [1:0]                          o_access_status
);

    logic [fswtc_pkg::DATA_W-1:0] r_mem [fswtc_pkg::MEM_WORDS];
    logic [fswtc_pkg::DATA_W-1:0] r_mem_rd;

    logic [fswtc_pkg::ADDR_W-1:0] r_tag [fswtc_pkg::ENTRIES];
    logic [fswtc_pkg::DATA_W-1:0] r_val [fswtc_pkg::ENTRIES];
    logic [fswtc_pkg::FILL_W-1:0] r_fill [fswtc_pkg::SET_CNT];

    logic                         r_func;
    logic [fswtc_pkg::ADDR_W-1:0] r_addr;
    logic [fswtc_pkg::DATA_W-1:0] r_wval;
    logic [fswtc_pkg::DATA_W-1:0] r_rd_val;
    fswtc_pkg::t_acc_status       r_status;

    logic [fswtc_pkg::SET_W-1:0]  w_set;
    logic                         w_hit;
    logic [fswtc_pkg::WAY_W-1:0]  w_hit_way;
    logic [fswtc_pkg::WAY_W-1:0]  w_fill_way;
    logic                         w_set_full;
    logic [fswtc_pkg::DATA_W-1:0] n_rd_val;
    fswtc_pkg::t_acc_status       n_status;

    assign w_set      = r_addr[fswtc_pkg::SET_LSB +: fswtc_pkg::SET_W];
    assign w_set_full = (r_fill[w_set] >= fswtc_pkg::FILL_W'(fswtc_pkg::WAYS));
    assign w_fill_way = w_set_full ? '0 : r_fill[w_set][fswtc_pkg::WAY_W-1:0];

    // tag compare over the valid slots of the set, highest slot wins
    always_comb begin
        w_hit     = 1'b0;
        w_hit_way = '0;
        for (int k = 0; k < fswtc_pkg::WAYS; k++) begin
            if ((fswtc_pkg::FILL_W'(k) < r_fill[w_set])
                && (r_tag[{w_set, fswtc_pkg::WAY_W'(k)}] == r_addr)) begin
                w_hit     = 1'b1;
                w_hit_way = fswtc_pkg::WAY_W'(k);
            end
        end
    end

    always_comb begin
        n_rd_val = r_mem_rd;
        n_status = fswtc_pkg::ACC_BYPASS;
        if (!i_bypass) begin
            n_status = w_hit ? fswtc_pkg::ACC_HIT : fswtc_pkg::ACC_MISS;
            if (w_hit) begin
                n_rd_val = r_val[{w_set, w_hit_way}];
            end
        end
        if (r_func) begin
            n_rd_val = '0;
        end
    end

    // request capture and backing memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_addr   <= i_word_address;
            r_wval   <= i_write_value;
            r_mem_rd <= r_mem[i_word_address[fswtc_pkg::MEM_AW-1:0]];
        end
        if (i_cmd.commit && r_func) begin
            r_mem[r_addr[fswtc_pkg::MEM_AW-1:0]] <= r_wval;
        end
    end

    // cache arrays: write hit updates value, read miss fills in slot order, then slot 0 once full
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !i_bypass) begin
            if (r_func && w_hit) begin
                r_val[{w_set, w_hit_way}] <= r_wval;
            end
            if (!r_func && !w_hit) begin
                r_tag[{w_set, w_fill_way}] <= r_addr;
                r_val[{w_set, w_fill_way}] <= r_mem_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < fswtc_pkg::SET_CNT; s++) begin
                r_fill[s] <= '0;
            end
        end else if (i_cmd.commit && !i_bypass && !r_func && !w_hit && !w_set_full) begin
            r_fill[w_set] <= r_fill[w_set] + fswtc_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rd_val <= n_rd_val;
            r_status <= n_status;
        end
    end

    assign o_read_value    = r_rd_val;
    assign o_access_status = r_status;

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] <= fswtc_pkg::FILL_W'(fswtc_pkg::WAYS))
        && (r_fill[1] <= fswtc_pkg::FILL_W'(fswtc_pkg::WAYS))
        && (r_fill[2] <= fswtc_pkg::FILL_W'(fswtc_pkg::WAYS))
        && (r_fill[3] <= fswtc_pkg::FILL_W'(fswtc_pkg::WAYS)))
        else $error("set fill count above way count");

    // a write result always carries a zero data word
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_func) |=> (o_read_value == '0))
        else $error("write result with nonzero data");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-set write-through cache.
// A shadow copy of memory, tags and fill counts predicts the read value and
// the bypass/hit/miss status of every access. The bench runs a directed fill
// and replacement sequence, a stale-copy check under bypass, then random
// traffic over a small pool of conflicting addresses and the full address
// range, with the bypass register toggled between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic FUNC_READ     = 1'b0;
    localparam logic FUNC_WRITE    = 1'b1;
    localparam int   STALL_LIMIT   = 500;
    localparam int   HOT_COUNT     = 24;
    localparam logic [fswtc_pkg::DATA_W-1:0] WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [fswtc_pkg::DATA_W-1:0] WORD_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic signed [fswtc_pkg::DATA_W-1:0] value;
        fswtc_pkg::t_acc_status              status;
    } t_access_result;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [fswtc_pkg::PADDR_W-1:0]       paddr;
    logic [fswtc_pkg::PDATA_W-1:0]       pwdata;
    logic [fswtc_pkg::PDATA_W-1:0]       prdata;
    logic                                pready;
    logic                                start;
    logic                                busy;
    logic                                i_func;
    logic [fswtc_pkg::ADDR_W-1:0]        i_word_address;
    logic signed [fswtc_pkg::DATA_W-1:0] i_write_value;
    logic                                o_done;
    logic signed [fswtc_pkg::DATA_W-1:0] o_read_value;
    logic [1:0]                          o_access_status;

    // shadow state of the block
    logic [fswtc_pkg::DATA_W-1:0]  shadow_mem [fswtc_pkg::MEM_WORDS];
    bit                            mem_written [fswtc_pkg::MEM_WORDS];
    logic [fswtc_pkg::ADDR_W-1:0]  written_addrs [$];
    logic [fswtc_pkg::ADDR_W-1:0]  tag_addr [fswtc_pkg::ENTRIES];
    logic [fswtc_pkg::DATA_W-1:0]  tag_value [fswtc_pkg::ENTRIES];
    logic [fswtc_pkg::FILL_W-1:0]  fill_cnt [fswtc_pkg::SET_CNT];
    logic                          bypass_mode;

    t_access_result                pending_results [$];
    logic [fswtc_pkg::ADDR_W-1:0]  hot_addrs [HOT_COUNT];
    int                            mismatch_count;
    int                            stall_cycles;
    bit                            no_idle;

    four_set_write_through_cache u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_word_address  (i_word_address),
        .i_write_value   (i_write_value),
        .o_done          (o_done),
        .o_read_value    (o_read_value),
        .o_access_status (o_access_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_access_result predict_access(
        input logic                         is_write,
        input logic [fswtc_pkg::ADDR_W-1:0] addr,
        input logic [fswtc_pkg::DATA_W-1:0] wval);
        t_access_result                res;
        logic [fswtc_pkg::SET_W-1:0]   set_idx;
        int                            hit_slot;
        int                            fill_slot;
        res.value = '0;
        res.status = fswtc_pkg::ACC_BYPASS;
        hit_slot = -1;
        set_idx = addr[fswtc_pkg::SET_LSB +: fswtc_pkg::SET_W];
        if (!bypass_mode) begin
            // highest slot first
            for (int k = fswtc_pkg::WAYS - 1; k >= 0; k--) begin
                if (hit_slot < 0 && k < fill_cnt[set_idx] &&
                    tag_addr[set_idx * fswtc_pkg::WAYS + k] == addr) begin
                    hit_slot = set_idx * fswtc_pkg::WAYS + k;
                end
            end
            res.status = (hit_slot >= 0) ? fswtc_pkg::ACC_HIT : fswtc_pkg::ACC_MISS;
        end
        if (is_write) begin
            if (hit_slot >= 0) begin
                tag_value[hit_slot] = wval;
            end
            shadow_mem[addr] = wval;
            if (!mem_written[addr]) begin
                mem_written[addr] = 1'b1;
                written_addrs.push_back(addr);
            end
        end else if (hit_slot >= 0) begin
            res.value = tag_value[hit_slot];
        end else begin
            res.value = shadow_mem[addr];
            if (!bypass_mode) begin
                if (fill_cnt[set_idx] < fswtc_pkg::WAYS) begin
                    fill_slot = fill_cnt[set_idx];
                    fill_cnt[set_idx] = fill_cnt[set_idx] + 1'b1;
                end else begin
                    fill_slot = 0;
                end
                tag_addr[set_idx * fswtc_pkg::WAYS + fill_slot] = addr;
                tag_value[set_idx * fswtc_pkg::WAYS + fill_slot] = res.value;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 20);
    endfunction

    function automatic logic [fswtc_pkg::DATA_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one request transfer; start stays high after acceptance so that
    // back-to-back requests need no second assignment in the same step
    task automatic send_access(input logic is_write,
                               input logic [fswtc_pkg::ADDR_W-1:0] addr,
                               input logic [fswtc_pkg::DATA_W-1:0] wval);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= is_write;
        i_word_address <= addr;
        i_write_value  <= is_write ? wval : rand_word();
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_access(is_write, addr, wval));
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic wr,
                                input logic [fswtc_pkg::PADDR_W-1:0] addr,
                                input logic [fswtc_pkg::PDATA_W-1:0] wdata,
                                output logic [fswtc_pkg::PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_bypass(input logic value);
        logic [fswtc_pkg::PADDR_W-1:0] reg_addr;
        logic [fswtc_pkg::PDATA_W-1:0] rdata;
        drain_pipeline();
        reg_addr = fswtc_pkg::PADDR_W'(fswtc_pkg::REG_CACHE_BYPASS) << 2;
        // upper data bits are don't-care, toggle them anyway
        apb_transfer(1'b1, reg_addr, {31'($urandom_range(0, 32'h7FFF_FFFF)), value}, rdata);
        bypass_mode = value;
        @(posedge i_clk);
        apb_transfer(1'b0, reg_addr, $urandom, rdata);
        if (rdata[0] !== value) begin
            if (mismatch_count < 10) begin
                $display("bypass register readback: expected %0b got %0b", value, rdata[0]);
            end
            mismatch_count++;
        end
    endtask

    task automatic test_fill_and_replace();
        logic [fswtc_pkg::ADDR_W-1:0] set0_addrs [4];
        set0_addrs = '{10'h040, 10'h080, 10'h0C0, 10'h100};
        send_access(FUNC_WRITE, 10'h000, '0);
        send_access(FUNC_READ,  10'h000, '0);
        send_access(FUNC_READ,  10'h000, '0);
        send_access(FUNC_WRITE, 10'h000, WORD_MAX);
        send_access(FUNC_READ,  10'h000, '0);
        send_access(FUNC_WRITE, 10'h3FF, WORD_MIN);
        send_access(FUNC_READ,  10'h3FF, '0);
        send_access(FUNC_READ,  10'h3FF, '0);
        foreach (set0_addrs[i]) send_access(FUNC_WRITE, set0_addrs[i], rand_word());
        // fourth read finds set 0 full and evicts slot 0
        foreach (set0_addrs[i]) send_access(FUNC_READ, set0_addrs[i], '0);
        send_access(FUNC_READ,  10'h000, '0);
        send_access(FUNC_READ,  10'h040, '0);
        send_access(FUNC_READ,  10'h100, '0);
        send_access(FUNC_WRITE, 10'h2AA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_access(FUNC_WRITE, 10'h155, 64'h5555_5555_5555_5555);
        send_access(FUNC_READ,  10'h2AA, '0);
        send_access(FUNC_READ,  10'h155, '0);
    endtask

    task automatic test_bypass_stale();
        send_access(FUNC_READ, 10'h0C0, '0);
        set_bypass(1'b1);
        send_access(FUNC_READ,  10'h0C0, '0);
        send_access(FUNC_WRITE, 10'h0C0, 64'h0123_4567_89AB_CDEF);
        send_access(FUNC_READ,  10'h0C0, '0);
        set_bypass(1'b0);
        // cached copy was not updated by the bypass write
        send_access(FUNC_READ,  10'h0C0, '0);
        send_access(FUNC_WRITE, 10'h0C0, 64'hFEDC_BA98_7654_3210);
        send_access(FUNC_READ,  10'h0C0, '0);
    endtask

    task automatic run_random_phase(input int n_items);
        logic [fswtc_pkg::ADDR_W-1:0] addr;
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (written_addrs.size() == 0 || $urandom_range(0, 99) < 40) begin
                if ($urandom_range(0, 99) < 60) begin
                    addr = hot_addrs[$urandom_range(0, HOT_COUNT - 1)];
                end else begin
                    addr = fswtc_pkg::ADDR_W'($urandom_range(0, fswtc_pkg::MEM_WORDS - 1));
                end
                send_access(FUNC_WRITE, addr, rand_word());
            end else begin
                // reads only ever target words that have been written
                addr = hot_addrs[$urandom_range(0, HOT_COUNT - 1)];
                if ($urandom_range(0, 99) >= 60 || !mem_written[addr]) begin
                    addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                end
                send_access(FUNC_READ, addr, '0);
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic modes [5];
        int   counts [5];
        modes  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        counts = '{400, 150, 400, 150, 400};
        // six addresses per set so that the sets overflow
        foreach (hot_addrs[i]) begin
            hot_addrs[i] = fswtc_pkg::ADDR_W'($urandom_range(0, fswtc_pkg::MEM_WORDS - 1));
            hot_addrs[i][fswtc_pkg::SET_LSB +: fswtc_pkg::SET_W] =
                fswtc_pkg::SET_W'(i % fswtc_pkg::SET_CNT);
        end
        foreach (modes[i]) begin
            set_bypass(modes[i]);
            run_random_phase(counts[i]);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result transfer: value %0d status %0d",
                             o_read_value, o_access_status);
                end
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.value || o_access_status !== want.status) begin
                    if (mismatch_count < 10) begin
                        $display("result mismatch: expected value %0d status %0d, got %0d %0d",
                                 want.value, want.status, o_read_value, o_access_status);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("** four_set_write_through_cache: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        start          <= 1'b0;
        i_func         <= FUNC_READ;
        i_word_address <= '0;
        i_write_value  <= '0;
        mismatch_count = 0;
        no_idle        = 1'b0;
        bypass_mode    = 1'b0;
        foreach (shadow_mem[i]) begin
            shadow_mem[i]  = '0;
            mem_written[i] = 1'b0;
        end
        foreach (tag_addr[i]) begin
            tag_addr[i]  = '0;
            tag_value[i] = '0;
        end
        foreach (fill_cnt[i]) fill_cnt[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_and_replace();
        test_bypass_stale();
        test_random_traffic();

        drain_pipeline();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("** four_set_write_through_cache: PASSED **");
        end else begin
            $display("** four_set_write_through_cache: FAILED **");
        end
        $finish;
    end

endmodule
